// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

  // bus phase of the engine
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START_A   = 5'd1,
    PH_START_B   = 5'd2,
    PH_START_C   = 5'd3,
    PH_BIT_LOW   = 5'd4,
    PH_BIT_HIGH  = 5'd5,
    PH_ACK_LOW   = 5'd6,
    PH_ACK_HIGH  = 5'd7,
    PH_WAIT_BYTE = 5'd8,
    PH_RS_LOW    = 5'd9,
    PH_RS_HIGH   = 5'd10,
    PH_RBIT_LOW  = 5'd11,
    PH_RBIT_HIGH = 5'd12,
    PH_MACK_LOW  = 5'd13,
    PH_MACK_HIGH = 5'd14,
    PH_STOP_A    = 5'd15,
    PH_STOP_B    = 5'd16,
    PH_STOP_C    = 5'd17
  } phase_e;

  // kind of the byte being shifted out
  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_RADDR = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_BYTE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUS_BUSY = 2'd1,
    ST_NO_ACK   = 2'd2
  } status_e;

  // register indexes on the configuration port
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd50;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

endpackage

// ===== hdl/i2c_master_register_access_core.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_data_i  (i2cm_pkg::in_t, one bus tick)
// out       output     out_valid_o/out_ready_i out_data_o (i2cm_pkg::out_t, line levels, status)
// config    input      APB psel/penable/pready paddr, pwdata, prdata
//
// One tick item per clock cycle sustained while out_ready_i holds; each item is
// processed in a single pass from the input register to the result register, so
// the result is registered only after the item has passed the input register.
// rst_ni is asynchronous, active low; it clears all engine state and restores
// half_period_ticks to 100 and ack_timeout to 50.
// A stalled result holds in the output register; the input register takes at most
// one more transaction, then in_ready_o drops until the result is taken.
module i2c_master_register_access_core import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic item_valid;
  logic item_take;
  in_t  item;

  i2cm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cm_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  i2cm_engine u_eng (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/i2cm_cfg_regs.sv =====
module i2cm_cfg_regs import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [15:0] half_period_q, half_period_d;
  logic [7:0]  ack_timeout_q, ack_timeout_d;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    half_period_d = half_period_q;
    ack_timeout_d = ack_timeout_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_HALF_PERIOD: half_period_d = pwdata[15:0];
        REG_ACK_TIMEOUT: ack_timeout_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else begin
      half_period_q <= half_period_d;
      ack_timeout_q <= ack_timeout_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_HALF_PERIOD: prdata = {16'd0, half_period_q};
      REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.half_period_ticks = half_period_q;
  assign cfg_o.ack_timeout       = ack_timeout_q;

endmodule

// ===== hdl/i2cm_in_stage.sv =====
module i2cm_in_stage import i2cm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic item_valid_o,
  input  logic item_take_i,
  output in_t  item_o
);

  logic valid_q, valid_d;
  in_t  data_q;
  logic load;

  // free when empty or being drained this cycle
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== hdl/i2cm_engine.sv =====
module i2cm_engine import i2cm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic item_valid_i,
  output logic item_take_o,
  input  in_t  item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [15:0] div_q, div_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  ack_wait_q, ack_wait_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic        read_mode_q, read_mode_d;
  logic [1:0]  end_status_q, end_status_d;

  logic        out_valid_q, out_valid_d;
  out_t        out_q, res;

  logic [15:0] half_period;
  logic        phase_end;
  logic [3:0]  bit_cnt_inc;
  logic        acked;
  logic        ack_decided;
  logic [7:0]  rx_byte;
  logic        rx_valid;
  logic        done;
  logic [1:0]  status;
  logic        scl;
  logic        sdo;

  // one item per cycle while the result register can take it
  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign half_period = (cfg_i.half_period_ticks == 16'd0) ? 16'd1 : cfg_i.half_period_ticks;
  assign phase_end   = ({1'b0, div_q} + 17'd1) >= {1'b0, half_period};
  assign bit_cnt_inc = bit_cnt_q + 4'd1;
  assign acked       = !item_i.sda_level;
  assign ack_decided = acked || (ack_wait_q >= cfg_i.ack_timeout);

  // next state for one tick
  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    div_d        = div_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    ack_wait_d   = ack_wait_q;
    dev_d        = dev_q;
    reg_d        = reg_q;
    read_mode_d  = read_mode_q;
    end_status_d = end_status_q;
    rx_byte      = 8'd0;
    rx_valid     = 1'b0;
    done         = 1'b0;
    status       = ST_OK;

    if (item_take_o) begin
      priority if (phase_q == PH_IDLE) begin
        if (item_i.command == CMD_WRITE || item_i.command == CMD_READ) begin
          dev_d        = item_i.device_address;
          reg_d        = item_i.register_address;
          bytes_left_d = item_i.length;
          read_mode_d  = (item_i.command == CMD_READ);
          kind_d       = KIND_ADDR;
          end_status_d = ST_OK;
          bit_cnt_d    = 4'd0;
          shift_d      = 8'd0;
          ack_wait_d   = 8'd0;
          div_d        = 16'd0;
          phase_d      = PH_START_A;
        end
      end else if (phase_q == PH_WAIT_BYTE) begin
        if (item_i.command == CMD_BYTE) begin
          bytes_left_d = bytes_left_q - 8'd1;
          div_d        = 16'd0;
          shift_d      = item_i.write_byte;
          kind_d       = KIND_DATA;
          bit_cnt_d    = 4'd0;
          phase_d      = PH_BIT_LOW;
        end
      end else if (!phase_end) begin
        div_d = div_q + 16'd1;
      end else begin
        div_d = 16'd0;
        unique case (phase_q)
          PH_START_A: begin
            if (!item_i.sda_level) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              status  = ST_BUS_BUSY;
            end else begin
              phase_d = PH_START_B;
            end
          end
          PH_START_B: phase_d = PH_START_C;
          PH_START_C: begin
            // repeated start sends the read address
            if (kind_q == KIND_REG) begin
              shift_d = {dev_q, 1'b1};
              kind_d  = KIND_RADDR;
            end else begin
              shift_d = {dev_q, 1'b0};
              kind_d  = KIND_ADDR;
            end
            bit_cnt_d = 4'd0;
            phase_d   = PH_BIT_LOW;
          end
          PH_BIT_LOW: phase_d = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= 4'd8) begin
              bit_cnt_d  = 4'd0;
              ack_wait_d = 8'd0;
              phase_d    = PH_ACK_LOW;
            end else begin
              phase_d = PH_BIT_LOW;
            end
          end
          PH_ACK_LOW: phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (!ack_decided) begin
              ack_wait_d = ack_wait_q + 8'd1;
            end else begin
              unique case (kind_q)
                KIND_ADDR: begin
                  if (acked) begin
                    shift_d   = reg_q;
                    kind_d    = KIND_REG;
                    bit_cnt_d = 4'd0;
                    phase_d   = PH_BIT_LOW;
                  end else begin
                    end_status_d = ST_NO_ACK;
                    phase_d      = PH_STOP_A;
                  end
                end
                // register byte ack level is ignored
                KIND_REG: begin
                  if (read_mode_q) begin
                    phase_d = PH_RS_LOW;
                  end else if (bytes_left_q == 8'd0) begin
                    phase_d = PH_STOP_A;
                  end else begin
                    phase_d = PH_WAIT_BYTE;
                  end
                end
                KIND_RADDR: begin
                  if (bytes_left_q == 8'd0) begin
                    phase_d = PH_STOP_A;
                  end else begin
                    shift_d   = 8'd0;
                    bit_cnt_d = 4'd0;
                    phase_d   = PH_RBIT_LOW;
                  end
                end
                // data byte NACK ends the write with OK status
                default: begin
                  if (!acked || bytes_left_q == 8'd0) begin
                    phase_d = PH_STOP_A;
                  end else begin
                    phase_d = PH_WAIT_BYTE;
                  end
                end
              endcase
            end
          end
          PH_RS_LOW:   phase_d = PH_RS_HIGH;
          PH_RS_HIGH:  phase_d = PH_START_B;
          PH_RBIT_LOW: phase_d = PH_RBIT_HIGH;
          PH_RBIT_HIGH: begin
            shift_d   = {shift_q[6:0], item_i.sda_level};
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= 4'd8) begin
              bit_cnt_d    = 4'd0;
              rx_byte      = {shift_q[6:0], item_i.sda_level};
              rx_valid     = 1'b1;
              bytes_left_d = bytes_left_q - 8'd1;
              phase_d      = PH_MACK_LOW;
            end else begin
              phase_d = PH_RBIT_LOW;
            end
          end
          PH_MACK_LOW: phase_d = PH_MACK_HIGH;
          PH_MACK_HIGH: begin
            if (bytes_left_q != 8'd0) begin
              shift_d   = 8'd0;
              bit_cnt_d = 4'd0;
              phase_d   = PH_RBIT_LOW;
            end else begin
              phase_d = PH_STOP_A;
            end
          end
          PH_STOP_A: phase_d = PH_STOP_B;
          PH_STOP_B: phase_d = PH_STOP_C;
          PH_STOP_C: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            status  = end_status_q;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // line levels after this tick
  always_comb begin
    unique case (phase_d)
      PH_START_A, PH_RS_HIGH, PH_ACK_HIGH, PH_RBIT_HIGH: begin
        scl = 1'b1; sdo = 1'b1;
      end
      PH_START_B, PH_STOP_B: begin
        scl = 1'b1; sdo = 1'b0;
      end
      PH_START_C, PH_STOP_A: begin
        scl = 1'b0; sdo = 1'b0;
      end
      PH_BIT_LOW: begin
        scl = 1'b0; sdo = shift_d[7];
      end
      PH_BIT_HIGH: begin
        scl = 1'b1; sdo = shift_d[7];
      end
      PH_ACK_LOW, PH_WAIT_BYTE, PH_RS_LOW, PH_RBIT_LOW: begin
        scl = 1'b0; sdo = 1'b1;
      end
      // master ack on all but the last byte
      PH_MACK_LOW: begin
        scl = 1'b0; sdo = (bytes_left_d == 8'd0);
      end
      PH_MACK_HIGH: begin
        scl = 1'b1; sdo = (bytes_left_d == 8'd0);
      end
      default: begin
        scl = 1'b1; sdo = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.scl_drive    = scl;
    res.sda_drive    = sdo;
    res.read_byte    = rx_byte;
    res.read_valid   = rx_valid;
    res.byte_request = (phase_d == PH_WAIT_BYTE);
    res.busy_res     = (phase_d != PH_IDLE);
    res.done_res     = done;
    res.status       = status;
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      kind_q       <= KIND_ADDR;
      div_q        <= 16'd0;
      bit_cnt_q    <= 4'd0;
      shift_q      <= 8'd0;
      bytes_left_q <= 8'd0;
      ack_wait_q   <= 8'd0;
      dev_q        <= 7'd0;
      reg_q        <= 8'd0;
      read_mode_q  <= 1'b0;
      end_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      div_q        <= div_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      bytes_left_q <= bytes_left_d;
      ack_wait_q   <= ack_wait_d;
      dev_q        <= dev_d;
      reg_q        <= reg_d;
      read_mode_q  <= read_mode_d;
      end_status_q <= end_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/i2cm_checker.sv =====
module i2cm_checker import i2cm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a finished transaction leaves the bus idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res
      && out_data_o.scl_drive && out_data_o.sda_drive)
    else $error("done reported with bus still active");

  // status only meaningful with done
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == ST_OK)
    else $error("status set without done");

  // waiting for a write byte stretches SCL low
  a_req_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_request |-> out_data_o.busy_res
      && !out_data_o.scl_drive && !out_data_o.done_res)
    else $error("byte request with SCL released");

  // a received byte comes mid transaction, data zero otherwise
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.read_valid && out_data_o.busy_res)
      || (!out_data_o.read_valid && out_data_o.read_byte == 8'd0))
    else $error("read data outside a read");

endmodule

bind i2c_master_register_access_core i2cm_checker u_i2cm_checker (.*);
